// ===== src/detection_row_filter_decode_unit_macros.svh =====
// assertion macros shared by the checker
`ifndef DETECTION_ROW_FILTER_DECODE_UNIT_MACROS_SVH
`define DETECTION_ROW_FILTER_DECODE_UNIT_MACROS_SVH

// same-cycle implication on clk_i, off while in reset
`define DRFD_ASSERT_IMPL(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("lbl failed");

// next-cycle implication on clk_i, off while in reset
`define DRFD_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("lbl failed");

`endif

// ===== src/drfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package drfd_pkg;

  localparam int MAX_CLASSES = 128;
  localparam int FRAC_BITS   = 12;

  localparam int VALUE_W   = 24;
  localparam int THR_CFG_W = 13;
  localparam int SCALE_W   = 16;
  localparam int NCLS_W    = 8;
  localparam int CLS_W     = 7;
  localparam int POS_W     = 8;
  localparam int PIX_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int CLS_CAP = (MAX_CLASSES < 128) ? MAX_CLASSES : 128;

  // threshold alignment from Q1.12 to the value format
  localparam int THR_SHL = (FRAC_BITS >= 12) ? FRAC_BITS - 12 : 0;
  localparam int THR_SHR = (FRAC_BITS < 12) ? 12 - FRAC_BITS : 0;
  localparam int THR_W   = THR_CFG_W + THR_SHL + 1;
  localparam int CMP_W   = VALUE_W + THR_W;

  localparam int DX_W   = VALUE_W + 2;
  localparam int PROD_W = DX_W + SCALE_W + 1;

  localparam int SH_EDGE = FRAC_BITS + 9;
  localparam int SH_SIZE = FRAC_BITS + 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONF_THR  = 3'd0,
    REG_SCORE_THR = 3'd1,
    REG_X_SCALE   = 3'd2,
    REG_Y_SCALE   = 3'd3,
    REG_NUM_CLS   = 3'd4
  } reg_index_e;

  localparam logic [THR_CFG_W-1:0] CONF_THR_RST  = 13'd2048;
  localparam logic [THR_CFG_W-1:0] SCORE_THR_RST = 13'd2048;
  localparam logic [SCALE_W-1:0]   X_SCALE_RST   = 16'd256;
  localparam logic [SCALE_W-1:0]   Y_SCALE_RST   = 16'd256;
  localparam logic [NCLS_W-1:0]    NUM_CLS_RST   = 8'd80;

  typedef struct packed {
    logic [THR_CFG_W-1:0] conf_thr;
    logic [THR_CFG_W-1:0] score_thr;
    logic [SCALE_W-1:0]   x_scale;
    logic [SCALE_W-1:0]   y_scale;
    logic [NCLS_W-1:0]    num_classes;
  } cfg_t;

  typedef struct packed {
    logic                      emit;
    logic signed [DX_W-1:0]    dx;
    logic signed [DX_W-1:0]    dy;
    logic signed [VALUE_W-1:0] w;
    logic signed [VALUE_W-1:0] h;
    logic [CLS_W-1:0]          best_class;
    logic signed [VALUE_W-1:0] conf;
  } row_result_t;

  function automatic logic signed [THR_W-1:0] align_thr(input logic [THR_CFG_W-1:0] thr);
    logic [THR_W-1:0] t;
    t = THR_W'(thr);
    t = (t << THR_SHL) >> THR_SHR;
    return $signed(t);
  endfunction

  // truncate toward zero after dropping sh fraction bits, then saturate
  function automatic logic signed [PIX_W-1:0] to_pixel(input logic signed [PROD_W-1:0] p,
                                                       input int unsigned sh);
    logic signed [PROD_W-1:0] bias;
    logic signed [PROD_W-1:0] q;
    logic signed [PROD_W-1:0] pix_max;
    logic signed [PROD_W-1:0] pix_min;
    pix_max = PROD_W'(32767);
    pix_min = -PROD_W'(32768);
    bias = p[PROD_W-1] ? ((PROD_W'(1) << sh) - PROD_W'(1)) : '0;
    q = (p + bias) >>> sh;
    if (q > pix_max) begin
      q = pix_max;
    end else if (q < pix_min) begin
      q = pix_min;
    end
    return q[PIX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/drfd_row_state.sv =====
`timescale 1ns / 1ps
`default_nettype none

module drfd_row_state (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               fire_i,
  input  wire logic signed [drfd_pkg::VALUE_W-1:0] value_i,
  input  wire logic                               frame_start_i,
  input  wire drfd_pkg::cfg_t                     cfg_i,
  output drfd_pkg::row_result_t                   res_o
);

  logic [drfd_pkg::POS_W-1:0]          position_q, position_d;
  logic signed [drfd_pkg::VALUE_W-1:0] center_x_q, center_x_d;
  logic signed [drfd_pkg::VALUE_W-1:0] center_y_q, center_y_d;
  logic signed [drfd_pkg::VALUE_W-1:0] box_w_q, box_w_d;
  logic signed [drfd_pkg::VALUE_W-1:0] box_h_q, box_h_d;
  logic signed [drfd_pkg::VALUE_W-1:0] obj_q, obj_d;
  logic signed [drfd_pkg::VALUE_W-1:0] best_score_q, best_score_d;
  logic [drfd_pkg::CLS_W-1:0]          best_class_q, best_class_d;

  logic [drfd_pkg::POS_W-1:0]  pos;
  logic [drfd_pkg::POS_W-1:0]  pos_off;
  logic [drfd_pkg::NCLS_W-1:0] ncls;
  logic [drfd_pkg::POS_W-1:0]  last;
  logic                        ends;
  logic                        conf_ok;
  logic                        score_ok;

  always_comb begin
    ncls = cfg_i.num_classes;
    if (ncls == '0) begin
      ncls = drfd_pkg::NCLS_W'(1);
    end
    if (ncls > drfd_pkg::NCLS_W'(drfd_pkg::CLS_CAP)) begin
      ncls = drfd_pkg::NCLS_W'(drfd_pkg::CLS_CAP);
    end
    last = drfd_pkg::POS_W'(4) + drfd_pkg::POS_W'(ncls);
  end

  always_comb begin
    pos          = frame_start_i ? '0 : position_q;
    pos_off      = pos - drfd_pkg::POS_W'(5);
    center_x_d   = center_x_q;
    center_y_d   = center_y_q;
    box_w_d      = box_w_q;
    box_h_d      = box_h_q;
    obj_d        = obj_q;
    best_score_d = best_score_q;
    best_class_d = best_class_q;
    case (pos)
      8'd0: center_x_d = value_i;
      8'd1: center_y_d = value_i;
      8'd2: box_w_d    = value_i;
      8'd3: box_h_d    = value_i;
      8'd4: obj_d      = value_i;
      8'd5: begin
        best_score_d = value_i;
        best_class_d = '0;
      end
      default: begin
        if (value_i > best_score_q) begin
          best_score_d = value_i;
          best_class_d = pos_off[drfd_pkg::CLS_W-1:0];
        end
      end
    endcase
    ends       = (pos >= last);
    position_d = ends ? '0 : pos + drfd_pkg::POS_W'(1);
  end

  always_comb begin
    conf_ok  = $signed(drfd_pkg::CMP_W'(obj_d))
             >= $signed(drfd_pkg::CMP_W'(drfd_pkg::align_thr(cfg_i.conf_thr)));
    score_ok = $signed(drfd_pkg::CMP_W'(best_score_d))
             > $signed(drfd_pkg::CMP_W'(drfd_pkg::align_thr(cfg_i.score_thr)));
    res_o.emit       = ends && conf_ok && score_ok;
    res_o.dx         = (drfd_pkg::DX_W'(center_x_q) <<< 1) - drfd_pkg::DX_W'(box_w_q);
    res_o.dy         = (drfd_pkg::DX_W'(center_y_q) <<< 1) - drfd_pkg::DX_W'(box_h_q);
    res_o.w          = box_w_q;
    res_o.h          = box_h_q;
    res_o.best_class = best_class_d;
    res_o.conf       = obj_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q   <= '0;
      center_x_q   <= '0;
      center_y_q   <= '0;
      box_w_q      <= '0;
      box_h_q      <= '0;
      obj_q        <= '0;
      best_score_q <= '0;
      best_class_q <= '0;
    end else if (fire_i) begin
      position_q   <= position_d;
      center_x_q   <= center_x_d;
      center_y_q   <= center_y_d;
      box_w_q      <= box_w_d;
      box_h_q      <= box_h_d;
      obj_q        <= obj_d;
      best_score_q <= best_score_d;
      best_class_q <= best_class_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/drfd_scaler.sv =====
`timescale 1ns / 1ps
`default_nettype none

module drfd_scaler (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                fire_i,
  input  wire drfd_pkg::row_result_t               res_i,
  input  wire drfd_pkg::cfg_t                      cfg_i,
  output logic                                     ready_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [drfd_pkg::PIX_W-1:0]        box_left_o,
  output logic signed [drfd_pkg::PIX_W-1:0]        box_top_o,
  output logic signed [drfd_pkg::PIX_W-1:0]        box_width_o,
  output logic signed [drfd_pkg::PIX_W-1:0]        box_height_o,
  output logic [drfd_pkg::CLS_W-1:0]               class_index_o,
  output logic signed [drfd_pkg::VALUE_W-1:0]      confidence_o
);

  logic signed [drfd_pkg::SCALE_W:0]   xs, ys;
  logic signed [drfd_pkg::PROD_W-1:0]  pl_q, pl_d, pt_q, pt_d, pw_q, pw_d, ph_q, ph_d;
  logic [drfd_pkg::CLS_W-1:0]          cls_q;
  logic signed [drfd_pkg::VALUE_W-1:0] conf_q;
  logic                                prod_valid_q;
  logic                                out_valid_q;
  logic                                ready_out;

  logic signed [drfd_pkg::PIX_W-1:0]   left_q, top_q, width_q, height_q;
  logic [drfd_pkg::CLS_W-1:0]          cls_out_q;
  logic signed [drfd_pkg::VALUE_W-1:0] conf_out_q;

  always_comb begin
    xs   = $signed({1'b0, cfg_i.x_scale});
    ys   = $signed({1'b0, cfg_i.y_scale});
    pl_d = res_i.dx * xs;
    pt_d = res_i.dy * ys;
    pw_d = res_i.w * xs;
    ph_d = res_i.h * ys;
  end

  assign ready_out = !out_valid_q || out_ready_i;
  assign ready_o   = !prod_valid_q || ready_out;

  // product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else if (ready_o) begin
      prod_valid_q <= fire_i && res_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && ready_o) begin
      pl_q   <= pl_d;
      pt_q   <= pt_d;
      pw_q   <= pw_d;
      ph_q   <= ph_d;
      cls_q  <= res_i.best_class;
      conf_q <= res_i.conf;
    end
  end

  // pixel output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_out) begin
      out_valid_q <= prod_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_valid_q && ready_out) begin
      left_q     <= drfd_pkg::to_pixel(pl_q, drfd_pkg::SH_EDGE);
      top_q      <= drfd_pkg::to_pixel(pt_q, drfd_pkg::SH_EDGE);
      width_q    <= drfd_pkg::to_pixel(pw_q, drfd_pkg::SH_SIZE);
      height_q   <= drfd_pkg::to_pixel(ph_q, drfd_pkg::SH_SIZE);
      cls_out_q  <= cls_q;
      conf_out_q <= conf_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign box_left_o    = left_q;
  assign box_top_o     = top_q;
  assign box_width_o   = width_q;
  assign box_height_o  = height_q;
  assign class_index_o = cls_out_q;
  assign confidence_o  = conf_out_q;

endmodule

`default_nettype wire

// ===== src/detection_row_filter_decode_unit.sv =====
// Detection row filter and decoder.
// Input channel (in_valid_i/in_ready_o): one signed Q12.12 row element per
// transaction, frame_start_i marks the first element of a new tensor.
// Each row is cx, cy, w, h, objectness, then num_classes class scores.
// Output channel (out_valid_o/out_ready_i): one detection transaction per row
// that passes both thresholds, carrying pixel box, class index, confidence.
// Throughput: one element per cycle while no detection is stalled, set by the
// single-pass row update and the four parallel box multipliers.
// Output path: the last element of a row passes the input register, the
// product register, then the pixel output register that drives out_valid_o.
// Stall: a waiting detection holds its payload; the two register stages in
// front keep taking elements until both hold work, then in_ready_o drops.
// Reset: row position and row state clear to zero, configuration registers
// take their defaults, no transaction is pending on either side.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i at once;
// write only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module detection_row_filter_decode_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [drfd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [drfd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [drfd_pkg::VALUE_W-1:0] value_i,
  input  wire logic                                frame_start_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [drfd_pkg::PIX_W-1:0]        box_left_o,
  output logic signed [drfd_pkg::PIX_W-1:0]        box_top_o,
  output logic signed [drfd_pkg::PIX_W-1:0]        box_width_o,
  output logic signed [drfd_pkg::PIX_W-1:0]        box_height_o,
  output logic [drfd_pkg::CLS_W-1:0]               class_index_o,
  output logic signed [drfd_pkg::VALUE_W-1:0]      confidence_o
);

  drfd_pkg::cfg_t        cfg_q;
  drfd_pkg::row_result_t row_res;

  logic                                in_valid_q;
  logic signed [drfd_pkg::VALUE_W-1:0] value_q;
  logic                                frame_start_q;
  logic                                scaler_ready;
  logic                                fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.conf_thr    <= drfd_pkg::CONF_THR_RST;
      cfg_q.score_thr   <= drfd_pkg::SCORE_THR_RST;
      cfg_q.x_scale     <= drfd_pkg::X_SCALE_RST;
      cfg_q.y_scale     <= drfd_pkg::Y_SCALE_RST;
      cfg_q.num_classes <= drfd_pkg::NUM_CLS_RST;
    end else if (cfg_we_i) begin
      case (drfd_pkg::reg_index_e'(cfg_index_i))
        drfd_pkg::REG_CONF_THR:  cfg_q.conf_thr    <= cfg_data_i[drfd_pkg::THR_CFG_W-1:0];
        drfd_pkg::REG_SCORE_THR: cfg_q.score_thr   <= cfg_data_i[drfd_pkg::THR_CFG_W-1:0];
        drfd_pkg::REG_X_SCALE:   cfg_q.x_scale     <= cfg_data_i[drfd_pkg::SCALE_W-1:0];
        drfd_pkg::REG_Y_SCALE:   cfg_q.y_scale     <= cfg_data_i[drfd_pkg::SCALE_W-1:0];
        drfd_pkg::REG_NUM_CLS:   cfg_q.num_classes <= cfg_data_i[drfd_pkg::NCLS_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !in_valid_q || scaler_ready;
  assign fire       = in_valid_q && scaler_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      value_q       <= value_i;
      frame_start_q <= frame_start_i;
    end
  end

  drfd_row_state u_row_state (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .value_i       (value_q),
    .frame_start_i (frame_start_q),
    .cfg_i         (cfg_q),
    .res_o         (row_res)
  );

  drfd_scaler u_scaler (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .res_i         (row_res),
    .cfg_i         (cfg_q),
    .ready_o       (scaler_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .box_left_o    (box_left_o),
    .box_top_o     (box_top_o),
    .box_width_o   (box_width_o),
    .box_height_o  (box_height_o),
    .class_index_o (class_index_o),
    .confidence_o  (confidence_o)
  );

endmodule

`default_nettype wire

// ===== src/drfd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "detection_row_filter_decode_unit_macros.svh"

module drfd_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_ready_o,
  input wire logic                                out_valid_o,
  input wire logic                                out_ready_i,
  input wire logic signed [drfd_pkg::PIX_W-1:0]   box_left_o,
  input wire logic signed [drfd_pkg::VALUE_W-1:0] confidence_o
);

  // input back-pressure only comes from a stalled detection
  `DRFD_ASSERT_IMPL(a_stall_source, !in_ready_o, out_valid_o && !out_ready_i)

  // a kept detection never has negative confidence
  `DRFD_ASSERT_IMPL(a_conf_sign, out_valid_o, !confidence_o[drfd_pkg::VALUE_W-1])

  // stalled detection stays
  `DRFD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

  // stalled detection keeps its payload
  `DRFD_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i,
                    $stable(box_left_o) && $stable(confidence_o))

endmodule

bind detection_row_filter_decode_unit drfd_checker u_drfd_checker (.*);

`default_nettype wire
